// ===== src/rule_line_syntax_checker_top_defines.svh =====
// Assertion macros for the rule line syntax checker.
`ifndef RULE_LINE_SYNTAX_CHECKER_TOP_DEFINES_SVH
`define RULE_LINE_SYNTAX_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RLSC_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RLSC_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== src/rlsc_pkg.sv =====
// Types and constants shared by the rule line syntax checker.
`timescale 1ns / 1ps
package rlsc_pkg;

   // Status codes reported at end of line
   localparam logic [3:0] ST_OK              = 4'd0;
   localparam logic [3:0] ST_NO_EQUAL        = 4'd1;
   localparam logic [3:0] ST_EXTRA_EQUAL     = 4'd2;
   localparam logic [3:0] ST_BAD_LEFT        = 4'd3;
   localparam logic [3:0] ST_BAD_START       = 4'd4;
   localparam logic [3:0] ST_BAD_SYMBOL      = 4'd5;
   localparam logic [3:0] ST_BAD_AFTER_QUOTE = 4'd6;
   localparam logic [3:0] ST_BAD_ESCAPE      = 4'd7;
   localparam logic [3:0] ST_UNTERMINATED    = 4'd8;

   // Right part parse phases
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_QUOTED = 3'd1;
   localparam logic [2:0] PH_SYMBOL = 3'd2;
   localparam logic [2:0] PH_CLOSED = 3'd3;
   localparam logic [2:0] PH_ESCAPE = 3'd4;

   // Character constants
   localparam logic [7:0] CH_EQUAL     = 8'h3d;
   localparam logic [7:0] CH_COMMA     = 8'h2c;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;

   localparam int POS_W = 12;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic             line_ok;
      logic [3:0]       status;
      logic [POS_W-1:0] error_position;
   } rsp_type;

   // Per-line parse state
   typedef struct packed {
      logic             in_right_part;
      logic [2:0]       right_phase;
      logic [3:0]       first_error;
      logic [POS_W-1:0] error_index;
      logic [POS_W-1:0] byte_index;
   } line_state_type;

endpackage

// ===== src/rlsc_step.sv =====
// Next-state and result logic for one request of the rule line checker.
`timescale 1ns / 1ps
module rlsc_step
   import rlsc_pkg::*;
#(
   parameter int MAX_LINE = 4096
) (
   input  line_state_type state,
   input  req_type        req,
   input  logic           single_equal_only,
   output line_state_type state_in,
   output rsp_type        rsp
);

   localparam int POS_CAP = ((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095;
   localparam logic [POS_W-1:0] CAP = POS_W'(POS_CAP);

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
   endfunction

   logic       hit;
   logic [3:0] code;
   logic [3:0] final_error;
   logic [POS_W-1:0] final_index;

   // Error detection and phase update for the current request
   always_comb begin
      state_in = state;
      hit      = 1'b0;
      code     = ST_OK;
      if (!req.line_end) begin
         if (state.byte_index < CAP) begin
            state_in.byte_index = state.byte_index + 1'b1;
         end
         if (state.first_error == ST_OK) begin
            if (!state.in_right_part) begin
               if (req.ch == CH_EQUAL) begin
                  state_in.in_right_part = 1'b1;
               end else if (!is_letter(req.ch)) begin
                  hit = 1'b1; code = ST_BAD_LEFT;
               end
            end else if ((req.ch == CH_EQUAL) && single_equal_only) begin
               hit = 1'b1; code = ST_EXTRA_EQUAL;
            end else begin
               case (state.right_phase)
                  PH_START: begin
                     if (is_letter(req.ch)) state_in.right_phase = PH_SYMBOL;
                     else if (req.ch == CH_QUOTE) state_in.right_phase = PH_QUOTED;
                     else begin hit = 1'b1; code = ST_BAD_START; end
                  end
                  PH_QUOTED: begin
                     if (req.ch == CH_QUOTE) state_in.right_phase = PH_CLOSED;
                     else if (req.ch == CH_BACKSLASH) state_in.right_phase = PH_ESCAPE;
                  end
                  PH_SYMBOL: begin
                     if (req.ch == CH_COMMA) state_in.right_phase = PH_START;
                     else if (!is_letter(req.ch)) begin
                        hit = 1'b1; code = ST_BAD_SYMBOL;
                     end
                  end
                  PH_CLOSED: begin
                     if (req.ch == CH_COMMA) state_in.right_phase = PH_START;
                     else begin hit = 1'b1; code = ST_BAD_AFTER_QUOTE; end
                  end
                  PH_ESCAPE: begin
                     if ((req.ch == CH_QUOTE) || (req.ch == CH_BACKSLASH)) begin
                        state_in.right_phase = PH_QUOTED;
                     end else begin
                        hit = 1'b1; code = ST_BAD_ESCAPE;
                     end
                  end
                  default: begin
                     hit = 1'b1; code = ST_BAD_SYMBOL;
                  end
               endcase
            end
         end
      end else if (state.first_error == ST_OK) begin
         // end of line checks
         if (!state.in_right_part) begin
            hit = 1'b1; code = ST_NO_EQUAL;
         end else begin
            case (state.right_phase)
               PH_SYMBOL, PH_CLOSED: hit = 1'b0;
               PH_START:  begin hit = 1'b1; code = ST_BAD_START; end
               PH_QUOTED: begin hit = 1'b1; code = ST_UNTERMINATED; end
               PH_ESCAPE: begin hit = 1'b1; code = ST_BAD_ESCAPE; end
               default:   begin hit = 1'b1; code = ST_BAD_SYMBOL; end
            endcase
         end
      end

      if (hit) begin
         state_in.first_error = code;
         state_in.error_index = state.byte_index;
      end
      final_error = state_in.first_error;
      final_index = state_in.error_index;

      // end item closes the line and starts a fresh one
      if (req.line_end) begin
         state_in.in_right_part = 1'b0;
         state_in.right_phase   = PH_START;
         state_in.first_error   = ST_OK;
         state_in.error_index   = '0;
         state_in.byte_index    = '0;
      end
   end

   // Result fields
   always_comb begin
      rsp.line_ok        = (final_error == ST_OK);
      rsp.status         = final_error;
      rsp.error_position = (final_error == ST_OK) ? '0 : final_index;
   end

endmodule

// ===== src/rule_line_syntax_checker_top.sv =====
// Top level of the rule line syntax checker: request stage, line state, result register.
// An end request's result passes through the request stage and then the result register.
// Throughput: one request per cycle; the only stall is an end request held in the
//   request stage while the result register is full and not taken.
// Byte requests produce no result; the registered line state update sets the rate.
// Reset (synchronous, active high) clears the line state and both valid flags and
//   sets single_equal_only to 1.
`timescale 1ns / 1ps
`include "rule_line_syntax_checker_top_defines.svh"
module rule_line_syntax_checker_top
   import rlsc_pkg::*;
#(
   parameter int MAX_LINE = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   localparam int POS_CAP = ((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095;

   logic           cfg_equal_ff;
   logic           stage_valid_ff;
   req_type        stage_req_ff;
   line_state_type state_ff;
   line_state_type state_in;
   rsp_type        rsp_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   logic           advance;
   logic           rsp_free;

   // Stage moves on unless it holds an end request with the result slot blocked
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && (!stage_req_ff.line_end || rsp_free);
   assign req_ready = !stage_valid_ff || advance;

   rlsc_step #(
      .MAX_LINE(MAX_LINE)
   ) u_step (
      .state            (state_ff),
      .req              (stage_req_ff),
      .single_equal_only(cfg_equal_ff),
      .state_in         (state_in),
      .rsp              (rsp_in)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_equal_ff <= 1'b1;
      end else if (csr_write_enable) begin
         cfg_equal_ff <= csr_write_data;
      end
   end

   // Request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         stage_req_ff <= req_data;
      end
   end

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{in_right_part: 1'b0, right_phase: PH_START, first_error: ST_OK,
                       error_index: '0, byte_index: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && stage_req_ff.line_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && stage_req_ff.line_end) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `RLSC_ASSERT_NOW(a_ok_clean, rsp_valid_ff && rsp_ff.line_ok,
      (rsp_ff.status == ST_OK) && (rsp_ff.error_position == '0),
      "ok result with error fields")
   `RLSC_ASSERT_NEXT(a_end_restarts, advance && stage_req_ff.line_end,
      rsp_valid_ff && (state_ff.byte_index == '0) && !state_ff.in_right_part,
      "end request did not restart line")
   `RLSC_ASSERT_NOW(a_no_err_index, state_ff.first_error == ST_OK,
      state_ff.error_index == '0, "error index set without error")
   `RLSC_ASSERT_NOW(a_pos_cap, 1'b1, state_ff.byte_index <= POS_W'(POS_CAP),
      "byte index beyond cap")

endmodule
